// File: sv/tscw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tscw_pkg;

    localparam int CELL_DEPTH = 2048;
    localparam int CELL_AW    = 11;
    localparam int CELL_W     = 16;
    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h07;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT  = 2'd0,
        FN_BKSP = 2'd1,
        FN_READ = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_BKSP,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  char_code;
        logic [BYTE_W-1:0]  tail;
        logic [CELL_AW-1:0] addr;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SHIFT,
        ST_PUTW,
        ST_CHECK,
        ST_SCROLL,
        ST_WIPE,
        ST_COMMIT,
        ST_RDA,
        ST_RDW,
        ST_DONE
    } t_back_state;

endpackage

`default_nettype wire

// File: sv/tscw_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tscw_in_if;
    import tscw_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [BYTE_W-1:0]  char_code;
    logic [BYTE_W-1:0]  tail_length;
    logic [CELL_AW-1:0] cell_addr;

    modport source (output valid, output func, output char_code, output tail_length,
                    output cell_addr, input ready);
    modport sink   (input valid, input func, input char_code, input tail_length,
                    input cell_addr, output ready);
endinterface

interface tscw_out_if;
    import tscw_pkg::*;

    logic               valid;
    logic               ready;
    logic [CELL_AW-1:0] cursor_pos;
    logic [CELL_W-1:0]  cell_value;
    logic               position_error;

    modport source (output valid, output cursor_pos, output cell_value,
                    output position_error, input ready);
    modport sink   (input valid, input cursor_pos, input cell_value,
                    input position_error, output ready);
endinterface

`default_nettype wire

// File: sv/tscw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tscw_front #(
    parameter int MAX_TAIL = 128
) (
    tscw_in_if.sink         i_in,
    input  wire logic       i_clearing,
    input  wire logic       i_push_ready,
    output logic            o_push,
    output tscw_pkg::t_cmd  o_push_cmd
);
    import tscw_pkg::*;

    logic [BYTE_W:0] tail_ext;

    assign tail_ext    = {1'b0, i_in.tail_length};
    assign i_in.ready  = i_push_ready & ~i_clearing;
    assign o_push      = i_in.valid & ~i_clearing;

    always_comb begin
        o_push_cmd.char_code = i_in.char_code;
        o_push_cmd.addr      = i_in.cell_addr;
        // clamp long tails
        if (tail_ext > (BYTE_W+1)'(MAX_TAIL)) begin
            o_push_cmd.tail = BYTE_W'(MAX_TAIL);
        end else begin
            o_push_cmd.tail = i_in.tail_length;
        end
        case (t_func'(i_in.func))
            FN_PUT: begin
                o_push_cmd.op = (i_in.char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
            end
            FN_BKSP: begin
                o_push_cmd.op = OP_BKSP;
            end
            FN_READ: begin
                o_push_cmd.op = OP_READ;
            end
            default: begin
                o_push_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/tscw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tscw_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tscw_pkg::t_cmd  i_push_cmd,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output tscw_pkg::t_cmd       o_pop_cmd,
    input  wire logic            i_pop
);
    import tscw_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_fire;
    logic       pop_fire;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_buf[r_rp];
    assign push_fire    = i_push & o_push_ready;
    assign pop_fire     = i_pop & o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_buf[r_wp] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_fire) begin
                r_wp <= ~r_wp;
            end
            if (pop_fire) begin
                r_rp <= ~r_rp;
            end
            if (push_fire && !pop_fire) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_fire && !push_fire) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/tscw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tscw_back #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCROLL_ROW     = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [7:0]              i_attr,
    input  wire logic                    i_cmd_valid,
    input  wire tscw_pkg::t_cmd          i_cmd,
    output logic                         o_cmd_ready,
    output logic                         o_clearing,
    tscw_out_if.source                   o_out
);
    import tscw_pkg::*;

    localparam int END_CELLS = SCROLL_ROW * SCREEN_COLUMNS;
    localparam int MOVED     = (SCROLL_ROW - 1) * SCREEN_COLUMNS;
    localparam int LIMIT     = (SCROLL_ROW + 1) * SCREEN_COLUMNS;
    localparam int CW        = ($clog2(END_CELLS + 1) > 9) ? $clog2(END_CELLS + 1) : 9;
    localparam int CLW       = $clog2(SCREEN_COLUMNS);
    localparam int RW        = $clog2(SCROLL_ROW + 2);
    localparam int PW        = CELL_AW + 1;

    t_back_state        r_state;
    t_back_state        n_state;

    logic [CELL_W-1:0]  r_mem [CELL_DEPTH];
    logic [CELL_W-1:0]  r_rdata;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_wa;
    logic [CELL_W-1:0]  mem_wd;
    logic [CELL_AW-1:0] mem_ra;

    t_cmd               r_cmd;
    logic [CELL_AW-1:0] r_cursor;
    logic [CLW-1:0]     r_col;
    logic [RW-1:0]      r_row;
    logic [PW-1:0]      r_pos;
    logic [CLW-1:0]     r_pcol;
    logic [RW-1:0]      r_prow;
    logic [CW-1:0]      r_cnt;
    logic [CELL_AW-1:0] r_src;
    logic [CELL_AW-1:0] r_dst;
    logic [CELL_AW-1:0] r_wdst;
    logic               r_wv;
    logic               r_down;
    logic               r_err;
    logic [CELL_W-1:0]  r_value;

    logic               r_out_valid;
    logic [CELL_AW-1:0] r_out_cursor;
    logic [CELL_W-1:0]  r_out_value;
    logic               r_out_err;

    logic               copy_done;
    logic               out_free;
    logic               pos_over;
    logic [CELL_AW-1:0] tail_a;

    assign copy_done = (r_cnt == '0) && !r_wv;
    assign out_free  = !r_out_valid || o_out.ready;
    assign pos_over  = r_pos[PW-1] || (32'(r_pos) > 32'(LIMIT));
    assign tail_a    = CELL_AW'(i_cmd.tail);

    assign o_out.valid          = r_out_valid;
    assign o_out.cursor_pos     = r_out_cursor;
    assign o_out.cell_value     = r_out_value;
    assign o_out.position_error = r_out_err;
    assign o_clearing           = (r_state == ST_CLEAR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_dst == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_PUT:     n_state = ST_SHIFT;
                        OP_BKSP:    n_state = ST_SHIFT;
                        OP_NEWLINE: n_state = ST_CHECK;
                        OP_READ:    n_state = ST_RDA;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_SHIFT: begin
                if (copy_done) begin
                    n_state = (r_cmd.op == OP_PUT) ? ST_PUTW : ST_CHECK;
                end
            end
            ST_PUTW: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (pos_over) begin
                    n_state = ST_DONE;
                end else if (r_prow >= RW'(SCROLL_ROW)) begin
                    n_state = ST_SCROLL;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_SCROLL: begin
                if (copy_done) begin
                    n_state = ST_WIPE;
                end
            end
            ST_WIPE: begin
                if (r_cnt == '0) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                n_state = ST_DONE;
            end
            ST_RDA: begin
                n_state = ST_RDW;
            end
            ST_RDW: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we      = 1'b0;
        mem_wa      = r_dst;
        mem_wd      = '0;
        mem_ra      = r_src;
        o_cmd_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
            end
            ST_SHIFT, ST_SCROLL: begin
                mem_we = r_wv;
                mem_wa = r_wdst;
                mem_wd = r_rdata;
            end
            ST_PUTW: begin
                mem_we = 1'b1;
                mem_wa = r_cursor;
                mem_wd = {i_attr, r_cmd.char_code};
            end
            ST_WIPE: begin
                mem_we = (r_cnt != '0);
            end
            ST_COMMIT: begin
                mem_we = 1'b1;
                mem_wa = r_pos[CELL_AW-1:0] + CELL_AW'(r_cmd.tail);
                mem_wd = {i_attr, BLANK_CHAR};
            end
            ST_RDA: begin
                mem_ra = r_cmd.addr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_dst       <= '0;
            r_cnt       <= '0;
            r_wv        <= 1'b0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_dst <= r_dst + CELL_AW'(1);
                end
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_value <= '0;
                        r_err   <= 1'b0;
                        r_wv    <= 1'b0;
                        case (i_cmd.op)
                            OP_PUT: begin
                                r_cnt  <= CW'(i_cmd.tail);
                                r_src  <= r_cursor + tail_a - CELL_AW'(1);
                                r_dst  <= r_cursor + tail_a;
                                r_down <= 1'b1;
                                r_pos  <= PW'(r_cursor) + PW'(1);
                                if (r_col == CLW'(SCREEN_COLUMNS - 1)) begin
                                    r_pcol <= '0;
                                    r_prow <= r_row + RW'(1);
                                end else begin
                                    r_pcol <= r_col + CLW'(1);
                                    r_prow <= r_row;
                                end
                            end
                            OP_BKSP: begin
                                r_down <= 1'b0;
                                if (r_cursor != '0) begin
                                    r_cnt <= CW'(i_cmd.tail) + CW'(1);
                                    r_src <= r_cursor;
                                    r_dst <= r_cursor - CELL_AW'(1);
                                    r_pos <= PW'(r_cursor) - PW'(1);
                                    if (r_col == '0) begin
                                        r_pcol <= CLW'(SCREEN_COLUMNS - 1);
                                        r_prow <= r_row - RW'(1);
                                    end else begin
                                        r_pcol <= r_col - CLW'(1);
                                        r_prow <= r_row;
                                    end
                                end else begin
                                    r_cnt  <= CW'(i_cmd.tail);
                                    r_src  <= CELL_AW'(1);
                                    r_dst  <= '0;
                                    r_pos  <= '0;
                                    r_pcol <= r_col;
                                    r_prow <= r_row;
                                end
                            end
                            OP_NEWLINE: begin
                                r_pos  <= PW'(r_cursor) + PW'(SCREEN_COLUMNS) - PW'(r_col);
                                r_pcol <= '0;
                                r_prow <= r_row + RW'(1);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SHIFT, ST_SCROLL: begin
                    if (r_cnt != '0) begin
                        r_cnt  <= r_cnt - CW'(1);
                        r_wv   <= 1'b1;
                        r_wdst <= r_dst;
                        r_src  <= r_down ? r_src - CELL_AW'(1) : r_src + CELL_AW'(1);
                        r_dst  <= r_down ? r_dst - CELL_AW'(1) : r_dst + CELL_AW'(1);
                    end else begin
                        r_wv <= 1'b0;
                        // set up the wipe from the cursor to the scroll row
                        if (r_state == ST_SCROLL && !r_wv) begin
                            r_cnt <= CW'(END_CELLS) - CW'(r_pos);
                            r_dst <= r_pos[CELL_AW-1:0];
                        end
                    end
                end
                ST_CHECK: begin
                    if (pos_over) begin
                        r_err <= 1'b1;
                    end else if (r_prow >= RW'(SCROLL_ROW)) begin
                        r_cnt  <= CW'(MOVED);
                        r_src  <= CELL_AW'(SCREEN_COLUMNS);
                        r_dst  <= '0;
                        r_down <= 1'b0;
                        r_pos  <= r_pos - PW'(SCREEN_COLUMNS);
                        r_prow <= r_prow - RW'(1);
                    end
                end
                ST_WIPE: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CW'(1);
                        r_dst <= r_dst + CELL_AW'(1);
                    end
                end
                ST_COMMIT: begin
                    r_cursor <= r_pos[CELL_AW-1:0];
                    r_col    <= r_pcol;
                    r_row    <= r_prow;
                end
                ST_RDW: begin
                    r_value <= r_rdata;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_cursor <= r_cursor;
                        r_out_value  <= r_value;
                        r_out_err    <= r_err;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/text_screen_char_writer_unit.sv
// Text screen writer over a 2048-cell screen memory, cells are attribute:char.
// Input channel i_in carries one command per beat: put character (code 10 is
// a newline), backspace, read one cell, or no operation. Output channel o_out
// returns one beat per command: the cursor after it, the cell read (zero for
// other commands) and a flag for a cursor that would leave the screen.
// i_cfg_we / i_cfg_wdata load the attribute byte used for written cells.
// Commands are classified on entry and held in a two-entry queue; the back
// end runs them one at a time with a cell memory of one write and one read
// port that moves one cell per cycle.
// A put or backspace shifts the tail (after clamping) by one cell. A cursor
// that passes the scroll row scrolls: the (SCROLL_ROW - 1) * SCREEN_COLUMNS
// cells below the top row move up one row and one row is cleared.
// After reset the back end clears all 2048 cells, one a cycle, before the
// first command is taken; the cursor is 0 and the attribute is 0x07.
// The output register frees the back end: while o_out is stalled, the next
// command is worked on and the queue keeps taking beats until full.
`timescale 1ns / 1ps
`default_nettype none

module text_screen_char_writer_unit #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCROLL_ROW     = 24,
    parameter int MAX_TAIL       = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    tscw_in_if.sink          i_in,
    tscw_out_if.source       o_out
);
    import tscw_pkg::*;

    logic [BYTE_W-1:0] r_text_attribute;
    logic              clearing;
    logic              push;
    t_cmd              push_cmd;
    logic              push_ready;
    logic              cmd_valid;
    t_cmd              cmd;
    logic              cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attribute <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_text_attribute <= i_cfg_wdata;
        end
    end

    tscw_front #(
        .MAX_TAIL (MAX_TAIL)
    ) u_front (
        .i_in         (i_in),
        .i_clearing   (clearing),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_push_cmd   (push_cmd)
    );

    tscw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (cmd_valid),
        .o_pop_cmd    (cmd),
        .i_pop        (cmd_ready)
    );

    tscw_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCROLL_ROW     (SCROLL_ROW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_text_attribute),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_clearing  (clearing),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
